// ----- src/wvpl_pkg.sv -----
package wvpl_pkg;

    // Sizing defaults
    localparam int MAX_SITES_DEF = 64;
    localparam int GRID_SIZE     = 512;

    // Field widths
    localparam int COORD_W    = 13;
    localparam int WGT_W      = 12;
    localparam int PIX_W      = 9;
    localparam int IDX_W      = 6;
    localparam int CNT_CFG_W  = 7;
    localparam int RAD_W      = 10;
    localparam int FRAC_W     = 8;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 2;
    localparam int W2_W       = 2 * WGT_W;
    localparam int R2_W       = 2 * RAD_W;
    localparam int PROD_W     = D2_W + W2_W;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(256);
    localparam logic [WGT_W-1:0] WEIGHT_MIN = WGT_W'(1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_RADIUS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_MODE = 2'd2;

    // Opcodes
    localparam logic OPC_LOAD     = 1'b0;
    localparam logic OPC_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [WGT_W-1:0]   w;
    } t_site;

    // One candidate site leaving the distance pipeline
    typedef struct packed {
        logic            valid;
        logic            first;
        logic [D2_W-1:0] d2;
        logic [W2_W-1:0] w2;
    } t_cand;

    // Phase control for the compare unit
    typedef struct packed {
        logic mul;
        logic cmp;
        logic fin;
    } t_best_ctl;

endpackage

// ----- src/weighted_voronoi_pixel_labeler.sv -----
// Weighted Voronoi pixel labeler.
// Input stream (s_axis_*): tuser selects the item kind. A load item writes
// one site entry (position, weight) into the site table and produces no
// result. A classify item takes one pixel and produces one result on the
// output stream (m_axis_*): the pixel, the site with the smallest distance
// divided by weight (lowest index on ties), and in tuser a labeled flag that
// is set when that weighted distance is below the reach radius.
// Configuration channel (i_cfg_*): site count, reach radius, weighted mode;
// write it only while no classify item is in flight.
// Flow: a load item is written without leaving the idle state. A classify
// item holds s_axis_tready low until its result has moved into the output
// register, so only one classify item is in flight at a time. The site table
// has one read port and the best-site compare loop alternates, per site, a
// cross-multiply phase with a compare-and-update phase; the scan reads the
// next site on each compare phase. The result sits in an output register;
// while the receiver stalls with that register full, the next finished
// result waits in the block and no new item is taken.
// Reset clears the configuration to site count 1, reach radius 250,
// unweighted mode; the site table content is undefined until loaded.
module weighted_voronoi_pixel_labeler #(
    parameter int MAX_SITES = wvpl_pkg::MAX_SITES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // s_axis_tdata: site_index[5:0], site_x[18:6], site_y[31:19],
    // site_weight[43:32], pixel_x[52:44], pixel_y[61:53], zero pad above
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [wvpl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,   // opcode
    // m_axis_tdata: out_x[8:0], out_y[17:9], nearest_site[23:18]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [wvpl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,   // labeled
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wvpl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wvpl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import wvpl_pkg::*;

    localparam int SIDX_W = $clog2(MAX_SITES);
    localparam int CNT_W  = $clog2(MAX_SITES + 1);
    localparam int NW     = CNT_W + CNT_CFG_W;

    // Input fields
    logic [IDX_W-1:0]   in_site_index;
    t_site              in_site;
    logic [PIX_W-1:0]   in_px;
    logic [PIX_W-1:0]   in_py;
    logic [PIX_W-1:0]   px_c;
    logic [PIX_W-1:0]   py_c;

    assign in_site_index = s_axis_tdata[5:0];
    assign in_site.x     = s_axis_tdata[18:6];
    assign in_site.y     = s_axis_tdata[31:19];
    assign in_site.w     = s_axis_tdata[43:32];
    assign in_px         = s_axis_tdata[52:44];
    assign in_py         = s_axis_tdata[61:53];

    // Configuration
    logic [CNT_CFG_W-1:0] r_site_count;
    logic [RAD_W-1:0]     r_reach;
    logic                 r_weighted;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_count <= CNT_CFG_W'(1);
            r_reach      <= RAD_W'(250);
            r_weighted   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SITE_COUNT:    r_site_count <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_REACH_RADIUS:  r_reach      <= i_cfg_data[RAD_W-1:0];
                CFG_WEIGHTED_MODE: r_weighted   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control and scan registers
    t_state             r_state;
    t_state             n_state;
    logic               r_phase;
    logic               r_issue;
    logic [SIDX_W-1:0]  r_addr;
    logic [SIDX_W-1:0]  r_last;
    logic [PIX_W-1:0]   r_px;
    logic [PIX_W-1:0]   r_py;
    logic [R2_W-1:0]    r_r2;
    logic               r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic               r_ouser;

    logic               in_acc;
    logic               load_we;
    logic               step;
    logic               out_load;
    t_best_ctl          best_ctl;
    logic [NW-1:0]      n_cnt;
    logic [SIDX_W-1:0]  last_idx;

    t_site              rdata;
    t_cand              cand;
    logic [SIDX_W-1:0]  cand_idx;
    logic               dist_busy;
    logic [SIDX_W-1:0]  best_idx;
    logic               labeled;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign load_we = in_acc && (s_axis_tuser == OPC_LOAD)
                     && (NW'(in_site_index) < NW'(MAX_SITES));

    // Clamp the pixel to the grid; clamp the site count to 1..MAX_SITES
    always_comb begin
        px_c = (COORD_W'(in_px) >= COORD_W'(GRID_SIZE)) ? PIX_W'(GRID_SIZE - 1) : in_px;
        py_c = (COORD_W'(in_py) >= COORD_W'(GRID_SIZE)) ? PIX_W'(GRID_SIZE - 1) : in_py;
        n_cnt = NW'(r_site_count);
        if (n_cnt == '0) begin
            n_cnt = NW'(1);
        end else if (n_cnt > NW'(MAX_SITES)) begin
            n_cnt = NW'(MAX_SITES);
        end
        last_idx = SIDX_W'(n_cnt - NW'(1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tuser == OPC_CLASSIFY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // last candidate is compared on this step and nothing follows it
                if (r_phase && !r_issue && !dist_busy && cand.valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_phase) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        step          = 1'b0;
        best_ctl      = '0;
        out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_SCAN: begin
                step         = r_phase;
                best_ctl.mul = !r_phase;
                best_ctl.cmp = r_phase;
            end
            S_FIN: begin
                best_ctl.mul = !r_phase;
                best_ctl.cmp = r_phase;
                best_ctl.fin = 1'b1;
            end
            S_DONE: begin
                out_load = !r_ovalid || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 1'b0;
            r_issue  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_phase <= 1'b0;
                r_issue <= in_acc && (s_axis_tuser == OPC_CLASSIFY);
            end else begin
                r_phase <= !r_phase;
                if (step && r_issue && (r_addr == r_last)) begin
                    r_issue <= 1'b0;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item payload: pixel, scan bounds, squared reach
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_px   <= px_c;
            r_py   <= py_c;
            r_addr <= '0;
            r_last <= last_idx;
            r_r2   <= R2_W'(r_reach) * R2_W'(r_reach);
        end else if (step && r_issue) begin
            r_addr <= r_addr + SIDX_W'(1);
        end
        if (out_load) begin
            r_odata <= {IDX_W'(best_idx), r_py, r_px};
            r_ouser <= labeled;
        end
    end

    wvpl_site_mem #(
        .MAX_SITES (MAX_SITES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (SIDX_W'(in_site_index)),
        .i_wdata (in_site),
        .i_re    (step && r_issue),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    wvpl_dist_unit #(
        .MAX_SITES (MAX_SITES)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_issue    (r_issue),
        .i_addr     (r_addr),
        .i_rdata    (rdata),
        .i_weighted (r_weighted),
        .i_qx       ({r_px, 4'b0000}),
        .i_qy       ({r_py, 4'b0000}),
        .o_cand     (cand),
        .o_cand_idx (cand_idx),
        .o_busy     (dist_busy)
    );

    wvpl_best_unit #(
        .MAX_SITES (MAX_SITES)
    ) u_best (
        .i_clk      (i_clk),
        .i_ctl      (best_ctl),
        .i_cand     (cand),
        .i_cand_idx (cand_idx),
        .i_r2       (r_r2),
        .o_best_idx (best_idx),
        .o_labeled  (labeled)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // Multiply and compare phases alternate while the scan runs
    a_phase_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_phase != $past(r_phase)))
        else $error("phase did not toggle during scan");

    // Final compare only after every site address has been issued
    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (!r_issue && !dist_busy))
        else $error("final pass with sites still in flight");

    // Classify item starts a scan on the next cycle
    a_classify_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser == OPC_CLASSIFY)) |=> (r_state == S_SCAN))
        else $error("classify item did not start a scan");

    // Finished result waits while the output register is full and stalled
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_ovalid && !m_axis_tready) |=> (r_state == S_DONE))
        else $error("result dropped under output stall");

endmodule

// ----- src/wvpl_site_mem.sv -----
module wvpl_site_mem #(
    parameter int MAX_SITES = wvpl_pkg::MAX_SITES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MAX_SITES)-1:0] i_waddr,
    input  wvpl_pkg::t_site              i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(MAX_SITES)-1:0] i_raddr,
    output wvpl_pkg::t_site              o_rdata
);
    import wvpl_pkg::*;

    t_site r_mem [MAX_SITES];
    t_site r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/wvpl_dist_unit.sv -----
module wvpl_dist_unit #(
    parameter int MAX_SITES = wvpl_pkg::MAX_SITES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_issue,
    input  logic [$clog2(MAX_SITES)-1:0] i_addr,
    input  wvpl_pkg::t_site              i_rdata,
    input  logic                         i_weighted,
    input  logic [wvpl_pkg::COORD_W-1:0] i_qx,
    input  logic [wvpl_pkg::COORD_W-1:0] i_qy,
    output wvpl_pkg::t_cand              o_cand,
    output logic [$clog2(MAX_SITES)-1:0] o_cand_idx,
    output logic                         o_busy
);
    import wvpl_pkg::*;

    localparam int SIDX_W = $clog2(MAX_SITES);

    logic              r_v_rd;
    logic [SIDX_W-1:0] r_idx_rd;
    logic              r_v_sq;
    logic [SIDX_W-1:0] r_idx_sq;
    logic [SQ_W-1:0]   r_dxsq;
    logic [SQ_W-1:0]   r_dysq;
    logic [W2_W-1:0]   r_w2;
    logic              r_cand_v;
    logic              r_cand_first;
    logic [D2_W-1:0]   r_cand_d2;
    logic [W2_W-1:0]   r_cand_w2;
    logic [SIDX_W-1:0] r_idx_d2;

    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [WGT_W-1:0]   weff;

    always_comb begin
        dx = (i_rdata.x >= i_qx) ? (i_rdata.x - i_qx) : (i_qx - i_rdata.x);
        dy = (i_rdata.y >= i_qy) ? (i_rdata.y - i_qy) : (i_qy - i_rdata.y);
        if (!i_weighted) begin
            weff = WEIGHT_ONE;
        end else if (i_rdata.w == '0) begin
            weff = WEIGHT_MIN;
        end else begin
            weff = i_rdata.w;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rd   <= 1'b0;
            r_v_sq   <= 1'b0;
            r_cand_v <= 1'b0;
        end else if (i_step) begin
            r_v_rd   <= i_issue;
            r_v_sq   <= r_v_rd;
            r_cand_v <= r_v_sq;
        end
    end

    // Squares, then the squared distance
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_idx_rd     <= i_addr;
            r_idx_sq     <= r_idx_rd;
            r_dxsq       <= SQ_W'(dx) * SQ_W'(dx);
            r_dysq       <= SQ_W'(dy) * SQ_W'(dy);
            r_w2         <= W2_W'(weff) * W2_W'(weff);
            r_idx_d2     <= r_idx_sq;
            r_cand_first <= (r_idx_sq == '0);
            r_cand_d2    <= D2_W'(r_dxsq) + D2_W'(r_dysq);
            r_cand_w2    <= r_w2;
        end
    end

    assign o_cand     = {r_cand_v, r_cand_first, r_cand_d2, r_cand_w2};
    assign o_cand_idx = r_idx_d2;
    assign o_busy     = r_v_rd | r_v_sq;

endmodule

// ----- src/wvpl_best_unit.sv -----
module wvpl_best_unit #(
    parameter int MAX_SITES = wvpl_pkg::MAX_SITES_DEF
) (
    input  logic                         i_clk,
    input  wvpl_pkg::t_best_ctl          i_ctl,
    input  wvpl_pkg::t_cand              i_cand,
    input  logic [$clog2(MAX_SITES)-1:0] i_cand_idx,
    input  logic [wvpl_pkg::R2_W-1:0]    i_r2,
    output logic [$clog2(MAX_SITES)-1:0] o_best_idx,
    output logic                         o_labeled
);
    import wvpl_pkg::*;

    localparam int SIDX_W = $clog2(MAX_SITES);

    logic [D2_W-1:0]   r_bd2;
    logic [W2_W-1:0]   r_bw2;
    logic [SIDX_W-1:0] r_bidx;
    logic [PROD_W-1:0] r_p1;
    logic [PROD_W-1:0] r_p2;
    logic              r_labeled;

    logic [D2_W-1:0] mul_a;
    logic [W2_W-1:0] mul_b;

    // Second multiplier doubles as reach^2 * w^2 on the final pass
    always_comb begin
        mul_a = i_ctl.fin ? D2_W'(i_r2) : r_bd2;
        mul_b = i_ctl.fin ? r_bw2 : i_cand.w2;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_p1 <= PROD_W'(i_cand.d2) * PROD_W'(r_bw2);
            r_p2 <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            if (i_ctl.fin) begin
                r_labeled <= ((PROD_W'(r_bd2) << FRAC_W) < r_p2);
            end else if (i_cand.valid && (i_cand.first || (r_p1 < r_p2))) begin
                r_bd2  <= i_cand.d2;
                r_bw2  <= i_cand.w2;
                r_bidx <= i_cand_idx;
            end
        end
    end

    assign o_best_idx = r_bidx;
    assign o_labeled  = r_labeled;

endmodule
